@@ sv/imfc_pkg.sv @@
// ----------------------------------------------------------------------------
// imfc_pkg
// Shared types and constants of the impedance motor frame codec.
// ----------------------------------------------------------------------------
package imfc_pkg;

	localparam int POS_BITS_DEF  = 16;
	localparam int DAMP_BITS_DEF = 9;
	localparam int CODE_BITS     = 12;
	localparam int LIM_W         = 31;
	localparam int DIV_W         = 32;
	localparam int QUO_W         = 32;
	localparam int LANES         = 5;
	localparam int SYM_LANES     = 3;
	localparam int LN_POS        = 0;
	localparam int LN_VEL        = 1;
	localparam int LN_TRQ        = 2;
	localparam int LN_STF        = 3;
	localparam int LN_DMP        = 4;
	localparam int IN_W          = 232;
	localparam int OUT_W         = 192;
	localparam int KIND_W        = 3;
	localparam int LEN_W         = 4;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;
	localparam int FIFO_DEPTH    = 4;
	localparam int FULL_LEN      = 8;
	localparam int TEMP_BIAS     = 25;

	localparam logic [LIM_W-1:0] POS_LIM_RST = 31'd819200;
	localparam logic [LIM_W-1:0] SPD_LIM_RST = 31'd2949120;
	localparam logic [LIM_W-1:0] TRQ_LIM_RST = 31'd2621440;
	localparam logic [LIM_W-1:0] STF_LIM_RST = 31'd32768000;
	localparam logic [LIM_W-1:0] DMP_LIM_RST = 31'd327680;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POS_LIM  = 3'd0,
		CFG_SPD_LIM  = 3'd1,
		CFG_TRQ_LIM  = 3'd2,
		CFG_STF_LIM  = 3'd3,
		CFG_DMP_LIM  = 3'd4,
		CFG_ZERO_OFF = 3'd5,
		CFG_MODE     = 3'd6
	} cfg_idx_e;

	typedef enum logic {
		CMD_ENC = 1'b0,
		CMD_DEC = 1'b1
	} cmd_e;

	typedef struct packed {
		logic [LIM_W-1:0] pos_lim;
		logic [LIM_W-1:0] spd_lim;
		logic [LIM_W-1:0] trq_lim;
		logic [LIM_W-1:0] stf_lim;
		logic [LIM_W-1:0] dmp_lim;
		logic signed [31:0] zero_off;
		logic [2:0] mode;
	} cfg_t;

	typedef struct packed {
		logic dec;
		logic ok;
		logic [LANES-1:0] zero;
		logic [KIND_W-1:0] kind;
		logic [4:0] fault;
		logic [7:0] temp;
		logic [7:0] drv;
	} side_t;

endpackage

@@ sv/imfc_div.sv @@
// ----------------------------------------------------------------------------
// imfc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module imfc_div #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	output logic [QW-1:0] q
);
	logic [NW-1:0] r_s [QW-1];
	logic [DW-1:0] d_s [QW-1];
	logic [QW-1:0] q_s [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		localparam int SH = QW - 1 - g;
		logic [NW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;
		logic [NW+DW-1:0] trial;
		logic ge;

		if (g == 0) begin : g_first
			assign r_in = n;
			assign d_in = d;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = r_s[g-1];
			assign d_in = d_s[g-1];
			assign q_in = q_s[g-1];
		end

		assign trial = (NW+DW)'(d_in) << SH;
		assign ge    = (NW+DW)'(r_in) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[g] <= q_in | (QW'(ge) << SH);
			end
		end

		if (g < QW - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[g] <= ge ? (r_in - trial[NW-1:0]) : r_in;
					d_s[g] <= d_in;
				end
			end
		end
	end

	assign q = q_s[QW-1];
endmodule

@@ sv/imfc_front.sv @@
// ----------------------------------------------------------------------------
// imfc_front
// Request intake: classify, clamp, and form dividend/divisor per field.
// ----------------------------------------------------------------------------
module imfc_front #(
	parameter int POS_BITS  = imfc_pkg::POS_BITS_DEF,
	parameter int DAMP_BITS = imfc_pkg::DAMP_BITS_DEF,
	parameter int NW        = 48,
	parameter int CW        = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  imfc_pkg::cfg_t             cfg,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [imfc_pkg::IN_W-1:0]  s_tdata,
	input  logic                       s_tuser,
	input  logic [CW-1:0]              fifo_count,
	output logic                       push,
	output imfc_pkg::side_t            side,
	output logic [NW-1:0]              n [imfc_pkg::LANES],
	output logic [imfc_pkg::DIV_W-1:0] d [imfc_pkg::LANES]
);
	import imfc_pkg::*;

	localparam int MB = NW - 32;
	localparam int LB [LANES] = '{POS_BITS, CODE_BITS, CODE_BITS, CODE_BITS, DAMP_BITS};

	logic signed [31:0] pos_t, vel_t, stf_t, dmp_t, trq_t;
	logic [63:0] rx;
	logic [LEN_W-1:0] rx_len;
	logic signed [32:0] p_rel;
	logic accept;
	logic [31:0] u [LANES];
	side_t side_d;
	logic [LIM_W-1:0] lim [LANES];

	logic vld_s1;
	logic [31:0] u_s1 [LANES];
	side_t side_s1;

	function automatic logic [31:0] clamp_sym(input logic signed [32:0] x,
		input logic [LIM_W-1:0] l);
		logic signed [33:0] s;
		logic [31:0] two_l;
		s     = {x[32], x} + $signed({3'b000, l});
		two_l = {l, 1'b0};
		if (s[33])
			return '0;
		else if (s[32:0] > {1'b0, two_l})
			return two_l;
		else
			return s[31:0];
	endfunction

	function automatic logic [31:0] clamp_pos(input logic signed [31:0] x,
		input logic [LIM_W-1:0] l);
		if (x[31])
			return '0;
		else if (x > $signed({1'b0, l}))
			return {1'b0, l};
		else
			return x;
	endfunction

	function automatic logic [NW-1:0] mul_m(input logic [31:0] v, input int b);
		return (NW'(v) << b) - NW'(v);
	endfunction

	assign pos_t  = s_tdata[31:0];
	assign vel_t  = s_tdata[63:32];
	assign stf_t  = s_tdata[95:64];
	assign dmp_t  = s_tdata[127:96];
	assign trq_t  = s_tdata[159:128];
	assign rx     = s_tdata[223:160];
	assign rx_len = s_tdata[227:224];

	assign lim[LN_POS] = cfg.pos_lim;
	assign lim[LN_VEL] = cfg.spd_lim;
	assign lim[LN_TRQ] = cfg.trq_lim;
	assign lim[LN_STF] = cfg.stf_lim;
	assign lim[LN_DMP] = cfg.dmp_lim;

	assign p_rel    = {pos_t[31], pos_t} - {cfg.zero_off[31], cfg.zero_off};
	assign s_tready = ({1'b0, fifo_count} + (CW+1)'(vld_s1)) < (CW+1)'(FIFO_DEPTH);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		side_d.dec   = (s_tuser == CMD_DEC);
		side_d.ok    = (s_tuser == CMD_ENC) || (rx_len >= LEN_W'(FULL_LEN));
		for (int l = 0; l < LANES; l++) side_d.zero[l] = (lim[l] == '0);
		side_d.kind  = rx[63:61];
		side_d.fault = rx[60:56];
		side_d.temp  = rx[15:8];
		side_d.drv   = rx[7:0];
		if (s_tuser == CMD_ENC) begin
			u[LN_POS] = clamp_sym(p_rel, cfg.pos_lim);
			u[LN_VEL] = clamp_sym({vel_t[31], vel_t}, cfg.spd_lim);
			u[LN_TRQ] = clamp_sym({trq_t[31], trq_t}, cfg.trq_lim);
			u[LN_STF] = clamp_pos(stf_t, cfg.stf_lim);
			u[LN_DMP] = clamp_pos(dmp_t, cfg.dmp_lim);
		end else begin
			u[LN_POS] = 32'(rx[40 +: POS_BITS]);
			u[LN_VEL] = 32'(rx[39:28]);
			u[LN_TRQ] = 32'(rx[27:16]);
			u[LN_STF] = '0;
			u[LN_DMP] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			side_s1 <= side_d;
			u_s1    <= u;
		end
	end

	assign push = vld_s1;
	assign side = side_s1;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (!side_s1.dec) begin
				n[l] = mul_m(u_s1[l], LB[l]);
				d[l] = (l < SYM_LANES) ? {lim[l], 1'b0} : {1'b0, lim[l]};
			end else if (l < SYM_LANES) begin
				n[l] = NW'(u_s1[l][MB-1:0]) * NW'({lim[l], 1'b0});
				d[l] = DIV_W'((1 << LB[l]) - 1);
			end else begin
				n[l] = '0;
				d[l] = DIV_W'(1);
			end
		end
	end
endmodule

@@ sv/imfc_fifo.sv @@
// ----------------------------------------------------------------------------
// imfc_fifo
// Short request queue between intake and divider back end.
// ----------------------------------------------------------------------------
module imfc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4,
	parameter int CW    = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [W-1:0]  din,
	input  logic          pop,
	output logic [W-1:0]  dout,
	output logic          empty,
	output logic [CW-1:0] count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0] mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	assign dout  = mem[rd_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != CW'(DEPTH)))
		else $error("request queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("request queue underflow");
endmodule

@@ sv/imfc_back.sv @@
// ----------------------------------------------------------------------------
// imfc_back
// Divider lanes, result formatting and output register.
// ----------------------------------------------------------------------------
module imfc_back #(
	parameter int POS_BITS  = imfc_pkg::POS_BITS_DEF,
	parameter int DAMP_BITS = imfc_pkg::DAMP_BITS_DEF,
	parameter int NW        = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  imfc_pkg::cfg_t              cfg,
	input  imfc_pkg::side_t             head_side,
	input  logic [NW-1:0]               head_n [imfc_pkg::LANES],
	input  logic [imfc_pkg::DIV_W-1:0]  head_d [imfc_pkg::LANES],
	input  logic                        empty,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [imfc_pkg::OUT_W-1:0]  m_tdata,
	output logic [imfc_pkg::KIND_W-1:0] m_tuser
);
	import imfc_pkg::*;

	localparam logic signed [34:0] S32_MAX = 35'sd2147483647;
	localparam logic signed [34:0] S32_MIN = -35'sd2147483648;

	logic adv;
	logic [QUO_W-1:0] vld_q;
	side_t side_q [QUO_W];
	logic [QUO_W-1:0] q [LANES];
	logic [QUO_W-1:0] code [LANES];
	logic [LIM_W-1:0] lim [SYM_LANES];
	logic signed [33:0] val [SYM_LANES];
	logic signed [34:0] psum;
	side_t sd;

	logic [63:0] tx;
	logic [LEN_W-1:0] txl;
	logic fbv;
	logic [KIND_W-1:0] kind;
	logic [4:0] fault;
	logic [31:0] mp, mv, mc;
	logic [8:0] coil;
	logic [7:0] drv;

	logic m_tvalid_q;
	logic [OUT_W-1:0] data_q;
	logic [KIND_W-1:0] user_q;

	assign adv = !m_tvalid_q || m_tready;
	assign pop = adv && !empty;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		imfc_div #(.NW(NW), .DW(DIV_W), .QW(QUO_W)) u_div (
			.clk (clk),
			.en  (adv),
			.n   (head_n[l]),
			.d   (head_d[l]),
			.q   (q[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[QUO_W-2:0], pop};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= head_side;
			for (int i = 1; i < QUO_W; i++) side_q[i] <= side_q[i-1];
		end
	end

	assign sd = side_q[QUO_W-1];
	assign lim[LN_POS] = cfg.pos_lim;
	assign lim[LN_VEL] = cfg.spd_lim;
	assign lim[LN_TRQ] = cfg.trq_lim;

	always_comb begin
		for (int l = 0; l < LANES; l++) code[l] = sd.zero[l] ? '0 : q[l];
		for (int l = 0; l < SYM_LANES; l++)
			val[l] = $signed({2'b00, q[l]}) - $signed({3'b000, lim[l]});
		psum = {val[LN_POS][33], val[LN_POS]} + {{3{cfg.zero_off[31]}}, cfg.zero_off};
		tx    = '0;
		txl   = '0;
		fbv   = 1'b0;
		kind  = '0;
		fault = '0;
		mp    = '0;
		mv    = '0;
		mc    = '0;
		coil  = '0;
		drv   = '0;
		if (!sd.dec) begin
			tx  = {cfg.mode, code[LN_STF][CODE_BITS-1:0], code[LN_DMP][8:0],
				code[LN_POS][15:0], code[LN_VEL][CODE_BITS-1:0],
				code[LN_TRQ][CODE_BITS-1:0]};
			txl = LEN_W'(FULL_LEN);
		end else if (sd.ok) begin
			fbv   = 1'b1;
			kind  = sd.kind;
			fault = sd.fault;
			if (psum > S32_MAX)
				mp = 32'h7FFF_FFFF;
			else if (psum < S32_MIN)
				mp = 32'h8000_0000;
			else
				mp = psum[31:0];
			mv   = val[LN_VEL][31:0];
			mc   = val[LN_TRQ][31:0];
			coil = {1'b0, sd.temp} - 9'(TEMP_BIAS);
			drv  = sd.drv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= vld_q[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= {5'b0, drv, coil, mc, mv, mp, fault, fbv, txl, tx};
			user_q <= kind;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(vld_q[QUO_W-1]))
		else $error("result shown without a request leaving the divider");
endmodule

@@ sv/impedance_motor_frame_codec.sv @@
// ----------------------------------------------------------------------------
// impedance_motor_frame_codec
// Encode/decode of impedance-mode motor CAN payloads.
// ----------------------------------------------------------------------------
// One request is taken per clock and one result leaves per clock while
// neither stream stalls. The intake register loads at the accepting edge.
// The request then passes through the 4-entry queue and 32 stages of the
// per-field restoring divider (one quotient bit per stage, five lanes side
// by side), and ends in the output register. A result held on m_tvalid
// freezes the divider pipeline. The queue then fills, and s_tready drops
// once the queue and intake hold four requests. Configuration writes take
// effect on the next cycle; write them only while no request is in flight.
module impedance_motor_frame_codec #(
	parameter int POS_BITS  = imfc_pkg::POS_BITS_DEF,
	parameter int DAMP_BITS = imfc_pkg::DAMP_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [imfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [imfc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// pos_target, vel_target, stiff_gain, damp_gain, torque_target,
	// rx_bytes, rx_length, zero pad
	input  logic [imfc_pkg::IN_W-1:0]        s_tdata,
	// cmd
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// tx_bytes, tx_length, fb_valid, fault_code, meas_pos, meas_vel,
	// meas_current, coil_temp, driver_temp, zero pad
	output logic [imfc_pkg::OUT_W-1:0]       m_tdata,
	// fb_kind
	output logic [imfc_pkg::KIND_W-1:0]      m_tuser
);
	import imfc_pkg::*;

	localparam int MB0  = (POS_BITS > DAMP_BITS) ? POS_BITS : DAMP_BITS;
	localparam int MB   = (MB0 > CODE_BITS) ? MB0 : CODE_BITS;
	localparam int NW   = 32 + MB;
	localparam int CW   = $clog2(FIFO_DEPTH + 1);
	localparam int SW   = $bits(side_t);
	localparam int LW   = NW + DIV_W;
	localparam int FW   = SW + LANES * LW;

	cfg_t cfg_q;

	logic push, pop, empty;
	logic [CW-1:0] fifo_count;
	side_t in_side, head_side;
	logic [NW-1:0] in_n [LANES];
	logic [DIV_W-1:0] in_d [LANES];
	logic [NW-1:0] head_n [LANES];
	logic [DIV_W-1:0] head_d [LANES];
	logic [FW-1:0] fifo_din, fifo_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_lim  <= POS_LIM_RST;
			cfg_q.spd_lim  <= SPD_LIM_RST;
			cfg_q.trq_lim  <= TRQ_LIM_RST;
			cfg_q.stf_lim  <= STF_LIM_RST;
			cfg_q.dmp_lim  <= DMP_LIM_RST;
			cfg_q.zero_off <= '0;
			cfg_q.mode     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_e'(cfg_index))
				CFG_POS_LIM:  cfg_q.pos_lim  <= cfg_data[LIM_W-1:0];
				CFG_SPD_LIM:  cfg_q.spd_lim  <= cfg_data[LIM_W-1:0];
				CFG_TRQ_LIM:  cfg_q.trq_lim  <= cfg_data[LIM_W-1:0];
				CFG_STF_LIM:  cfg_q.stf_lim  <= cfg_data[LIM_W-1:0];
				CFG_DMP_LIM:  cfg_q.dmp_lim  <= cfg_data[LIM_W-1:0];
				CFG_ZERO_OFF: cfg_q.zero_off <= cfg_data[31:0];
				CFG_MODE:     cfg_q.mode     <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	imfc_front #(.POS_BITS(POS_BITS), .DAMP_BITS(DAMP_BITS), .NW(NW), .CW(CW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.fifo_count (fifo_count),
		.push       (push),
		.side       (in_side),
		.n          (in_n),
		.d          (in_d)
	);

	assign fifo_din[SW-1:0] = in_side;
	assign head_side        = fifo_dout[SW-1:0];
	for (genvar l = 0; l < LANES; l++) begin : g_pack
		assign fifo_din[SW + l*LW +: NW]         = in_n[l];
		assign fifo_din[SW + l*LW + NW +: DIV_W] = in_d[l];
		assign head_n[l] = fifo_dout[SW + l*LW +: NW];
		assign head_d[l] = fifo_dout[SW + l*LW + NW +: DIV_W];
	end

	imfc_fifo #(.W(FW), .DEPTH(FIFO_DEPTH), .CW(CW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (fifo_din),
		.pop    (pop),
		.dout   (fifo_dout),
		.empty  (empty),
		.count  (fifo_count)
	);

	imfc_back #(.POS_BITS(POS_BITS), .DAMP_BITS(DAMP_BITS), .NW(NW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_side (head_side),
		.head_n    (head_n),
		.head_d    (head_d),
		.empty     (empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);
endmodule

@@ verif/tb_impedance_motor_frame_codec.sv @@
// ----------------------------------------------------------------------------
// tb_impedance_motor_frame_codec
// Self-checking bench: a directed table of encode/decode requests, then random
// requests under several register settings and idle patterns on both streams.
// Every result is checked field by field against a predictor or a table value.
// ----------------------------------------------------------------------------
module tb_impedance_motor_frame_codec;
	import imfc_pkg::*;

	localparam int WDOG_LIMIT = 4000;
	localparam int DRAIN_CYC  = 48;

	typedef struct {
		cmd_e               cmd;
		logic signed [31:0] pos, vel, stf, dmp, trq;
		logic [63:0]        rx;
		logic [3:0]         rlen;
	} req_t;

	typedef struct {
		logic [63:0]        tx;
		logic [3:0]         txlen;
		logic               ok;
		logic [2:0]         kind;
		logic [4:0]         fault;
		logic signed [31:0] mpos, mvel, mcur;
		logic [8:0]         ctemp;
		logic [7:0]         dtemp;
	} frame_res_t;

	typedef struct {
		req_t       req;
		bit         known;
		frame_res_t want;
	} row_t;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  cfg_we = 0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  s_tuser = 0;
	logic                  m_tvalid;
	logic                  m_tready = 0;
	logic [OUT_W-1:0]      m_tdata;
	logic [KIND_W-1:0]     m_tuser;

	impedance_motor_frame_codec dut (.*);

	always #5 clk = ~clk;

	// register image
	longint lim_pos, lim_spd, lim_trq, lim_stf, lim_dmp, zoff;
	logic [2:0] mode;

	frame_res_t pending[$];
	int errors = 0, n_enc = 0, n_dec = 0, n_cfg = 0, wdog = 0;
	int snd_idle = 0, rcv_idle = 0;

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h want %h", what, got, want);
		errors++;
	endtask

	function automatic longint code_sym(longint x, longint lim, longint m);
		if (lim == 0) return 0;
		if (x > lim) x = lim;
		if (x < -lim) x = -lim;
		return ((x + lim) * m) / (2 * lim);
	endfunction

	function automatic longint code_uni(longint x, longint lim, longint m);
		if (lim == 0) return 0;
		if (x < 0) x = 0;
		if (x > lim) x = lim;
		return (x * m) / lim;
	endfunction

	function automatic longint value_sym(longint raw, longint lim, longint m);
		if (lim == 0) return 0;
		return (raw * 2 * lim) / m - lim;
	endfunction

	function automatic frame_res_t codec_predict(req_t r);
		frame_res_t o;
		longint p;
		o = '{default: '0};
		if (r.cmd == CMD_ENC) begin
			p = longint'(r.pos) - zoff;
			o.tx = {mode,
				12'(code_uni(r.stf, lim_stf, 4095)),
				9'(code_uni(r.dmp, lim_dmp, 511)),
				16'(code_sym(p, lim_pos, 65535)),
				12'(code_sym(r.vel, lim_spd, 4095)),
				12'(code_sym(r.trq, lim_trq, 4095))};
			o.txlen = FULL_LEN;
		end else if (r.rlen >= FULL_LEN) begin
			p = value_sym(r.rx[55:40], lim_pos, 65535) + zoff;
			if (p > 64'sh7FFFFFFF) p = 64'sh7FFFFFFF;
			if (p < -64'sh80000000) p = -64'sh80000000;
			o.ok    = 1;
			o.kind  = r.rx[63:61];
			o.fault = r.rx[60:56];
			o.mpos  = p[31:0];
			o.mvel  = 32'(value_sym(r.rx[39:28], lim_spd, 4095));
			o.mcur  = 32'(value_sym(r.rx[27:16], lim_trq, 4095));
			o.ctemp = 9'({1'b0, r.rx[15:8]} - TEMP_BIAS);
			o.dtemp = r.rx[7:0];
		end
		return o;
	endfunction

	task automatic write_reg(cfg_idx_e idx, logic [31:0] v);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		case (idx)
			CFG_POS_LIM:  lim_pos = v[30:0];
			CFG_SPD_LIM:  lim_spd = v[30:0];
			CFG_TRQ_LIM:  lim_trq = v[30:0];
			CFG_STF_LIM:  lim_stf = v[30:0];
			CFG_DMP_LIM:  lim_dmp = v[30:0];
			CFG_ZERO_OFF: zoff = longint'(signed'(v));
			CFG_MODE:     mode = v[2:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	// lets every request drain, then writes a whole register set
	task automatic set_regs(logic [31:0] pl, sl, tl, kl, dl, zo, md);
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		write_reg(CFG_POS_LIM, pl);
		write_reg(CFG_SPD_LIM, sl);
		write_reg(CFG_TRQ_LIM, tl);
		write_reg(CFG_STF_LIM, kl);
		write_reg(CFG_DMP_LIM, dl);
		write_reg(CFG_ZERO_OFF, zo);
		write_reg(CFG_MODE, md);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic send_request(req_t r, bit known, frame_res_t want);
		while ($urandom_range(0, 99) < snd_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= r.cmd;
		s_tdata  <= {4'b0, r.rlen, r.rx, r.trq, r.dmp, r.stf, r.vel, r.pos};
		do @(posedge clk); while (!s_tready);
		pending.push_back(known ? want : codec_predict(r));
		if (r.cmd == CMD_ENC) n_enc++; else n_dec++;
	endtask

	function automatic logic [31:0] near_lim(longint lim, bit sym);
		longint v;
		case ($urandom_range(0, 3))
			0: v = lim + $urandom_range(0, 3);
			1: v = sym ? -lim - $urandom_range(0, 3) : -longint'($urandom_range(0, 3));
			2: v = lim - $urandom_range(0, 3);
			default: v = longint'($urandom_range(0, 2 * 32'(lim))) - (sym ? lim : 0);
		endcase
		if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
		if (v < -64'sh80000000) v = -64'sh80000000;
		return v[31:0];
	endfunction

	function automatic req_t rand_request();
		req_t r;
		bit wide;
		wide   = ($urandom_range(0, 3) == 0);
		r.cmd  = cmd_e'($urandom_range(0, 1));
		r.pos  = wide ? $urandom : near_lim(lim_pos, 1) + 32'(zoff);
		r.vel  = wide ? $urandom : near_lim(lim_spd, 1);
		r.stf  = wide ? $urandom : near_lim(lim_stf, 0);
		r.dmp  = wide ? $urandom : near_lim(lim_dmp, 0);
		r.trq  = wide ? $urandom : near_lim(lim_trq, 1);
		r.rx   = {$urandom, $urandom};
		r.rlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 15);
		return r;
	endfunction

	function automatic logic [31:0] rand_lim();
		logic [31:0] v;
		case ($urandom_range(0, 2))
			0: v = $urandom_range(1, 1000);
			1: v = $urandom_range(1, 32'h00FF_FFFF);
			default: v = $urandom_range(1, 32'h7FFF_FFFF);
		endcase
		return {1'($urandom), v[30:0]};
	endfunction

	function automatic req_t mk_enc(logic [31:0] p, v, k, d, t);
		req_t r;
		r = '{cmd: CMD_ENC, pos: p, vel: v, stf: k, dmp: d, trq: t, rx: '0, rlen: '0};
		return r;
	endfunction

	function automatic req_t mk_dec(logic [63:0] rx, logic [3:0] len);
		req_t r;
		r = '{cmd: CMD_DEC, pos: '0, vel: '0, stf: '0, dmp: '0, trq: '0, rx: rx, rlen: len};
		return r;
	endfunction

	// result check
	always @(posedge clk) begin
		frame_res_t g, w;
		m_tready <= ($urandom_range(0, 99) >= rcv_idle);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog = 0;
		else wdog++;
		if (wdog >= WDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			g.tx    = m_tdata[63:0];
			g.txlen = m_tdata[67:64];
			g.ok    = m_tdata[68];
			g.fault = m_tdata[73:69];
			g.mpos  = m_tdata[105:74];
			g.mvel  = m_tdata[137:106];
			g.mcur  = m_tdata[169:138];
			g.ctemp = m_tdata[178:170];
			g.dtemp = m_tdata[186:179];
			g.kind  = m_tuser;
			if (pending.size() == 0) begin
				report("unexpected result", m_tdata[63:0], '0);
			end else begin
				w = pending.pop_front();
				if (g.tx !== w.tx) report("tx_bytes", g.tx, w.tx);
				if (g.txlen !== w.txlen) report("tx_length", g.txlen, w.txlen);
				if (g.ok !== w.ok) report("fb_valid", g.ok, w.ok);
				if (g.kind !== w.kind) report("fb_kind", g.kind, w.kind);
				if (g.fault !== w.fault) report("fault_code", g.fault, w.fault);
				if (g.mpos !== w.mpos) report("meas_pos", g.mpos, w.mpos);
				if (g.mvel !== w.mvel) report("meas_vel", g.mvel, w.mvel);
				if (g.mcur !== w.mcur) report("meas_current", g.mcur, w.mcur);
				if (g.ctemp !== w.ctemp) report("coil_temp", g.ctemp, w.ctemp);
				if (g.dtemp !== w.dtemp) report("driver_temp", g.dtemp, w.dtemp);
			end
		end
	end

	initial begin
		row_t table_rows[$];
		row_t row;
		frame_res_t z, d0, e0;
		lim_pos = POS_LIM_RST; lim_spd = SPD_LIM_RST; lim_trq = TRQ_LIM_RST;
		lim_stf = STF_LIM_RST; lim_dmp = DMP_LIM_RST; zoff = 0; mode = 0;

		z = '{default: '0};
		e0 = z; e0.txlen = FULL_LEN;
		d0 = z; d0.ok = 1; d0.mpos = -32'sd819200; d0.mvel = -32'sd2949120;
		d0.mcur = -32'sd2621440; d0.ctemp = 9'h1E7;

		row = '{mk_enc(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF), 1, e0};
		row.want.tx = 64'h1FFF_FFFF_FFFF_FFFF;
		table_rows.push_back(row);
		table_rows.push_back('{mk_enc(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000), 1, e0});
		table_rows.push_back('{mk_enc(0, 0, 0, 0, 0), 0, z});
		table_rows.push_back('{mk_enc(819200, -2949120, 32768000, 327680, 2621440), 0, z});
		table_rows.push_back('{mk_enc(-819200, 2949121, 32768001, 327681, -2621441), 0, z});
		table_rows.push_back('{mk_enc(-1, 1, -1, -1, 1), 0, z});
		table_rows.push_back('{mk_enc(32'h5555AAAA, 32'hAAAA5555, 32'h12345678,
			32'h00012345, 32'hFEDCBA98), 0, z});
		table_rows.push_back('{mk_dec(64'hFFFF_FFFF_FFFF_FFFF, 0), 1, z});
		table_rows.push_back('{mk_dec(64'hFFFF_FFFF_FFFF_FFFF, 7), 1, z});
		table_rows.push_back('{mk_dec(64'h0, 8), 1, d0});
		table_rows.push_back('{mk_dec(64'hFFFF_FFFF_FFFF_FFFF, 15), 0, z});
		table_rows.push_back('{mk_dec(64'hAAAA_AAAA_AAAA_AAAA, 9), 0, z});
		table_rows.push_back('{mk_dec(64'h5555_5555_5555_5555, 8), 0, z});
		table_rows.push_back('{mk_dec(64'h1F00_0000_0000_1900, 8), 0, z});
		table_rows.push_back('{mk_dec(64'hE0FF_FFFF_FFFF_FFFF, 10), 0, z});

		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (table_rows[i])
			send_request(table_rows[i].req, table_rows[i].known, table_rows[i].want);

		for (int seg = 0; seg < 9; seg++) begin
			case (seg % 3)
				0: begin snd_idle = 37; rcv_idle = 68; end
				1: begin snd_idle = 68; rcv_idle = 37; end
				default: begin snd_idle = 0; rcv_idle = 0; end
			endcase
			s_tvalid <= 0;
			case (seg)
				0: set_regs(1, 1, 1, 1, 1, 32'h80000000, 7);
				1: set_regs(32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
					32'h7FFFFFFF, 32'h7FFFFFFF, 5);
				2: set_regs(POS_LIM_RST, SPD_LIM_RST, TRQ_LIM_RST, STF_LIM_RST,
					DMP_LIM_RST, 0, 2);
				default: set_regs(rand_lim(), rand_lim(), rand_lim(), rand_lim(),
					rand_lim(), $urandom, $urandom);
			endcase
			repeat (104) send_request(rand_request(), 0, z);
		end
		s_tvalid <= 0;

		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		$display("Covered %0d encode and %0d decode requests, %0d register writes,",
			n_enc, n_dec, n_cfg);
		$display("under reset, extreme and random settings with stalls on both streams.");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
